>>> rtl/lfpd_pkg.sv
package lfpd_pkg;

   localparam int NUM_SENSORS    = 5;
   localparam int ADC_BITS       = 12;
   localparam int GAIN_FRAC_BITS = 12;
   localparam int NORM_BITS      = 10;
   localparam int ERR_BITS       = 13;
   localparam int INT_BITS       = 24;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int DRIVE_BITS     = 9;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [NORM_BITS-1:0] NORM_FULL   = 10'd1000;
   localparam logic [NORM_BITS-1:0] ON_LEVEL    = 10'd700;
   localparam logic [5:0]           THICK_LIMIT = 6'd22;
   localparam logic [7:0]           RAMP_RESET  = 8'd30;
   localparam logic [4:0]           BRAKE_MS    = 5'd30;
   localparam logic signed [DRIVE_BITS-1:0] TURN_FWD   = 9'sd150;
   localparam logic signed [DRIVE_BITS-1:0] TURN_REV   = -9'sd100;
   localparam logic signed [DRIVE_BITS-1:0] SPIN_SPEED = 9'sd50;

   typedef enum logic [1:0] {
      CMD_CAL_START  = 2'd0,
      CMD_CAL_SAMPLE = 2'd1,
      CMD_FOLLOW     = 2'd2,
      CMD_STOP       = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_BLACK_LINE = 3'd0,
      CSR_THICKNESS  = 3'd1,
      CSR_BRAKE      = 3'd2,
      CSR_TARGET     = 3'd3,
      CSR_GAIN_P     = 3'd4,
      CSR_GAIN_I     = 3'd5,
      CSR_GAIN_D     = 3'd6
   } csr_index_type;

   typedef logic [ADC_BITS-1:0] sample_type [NUM_SENSORS];

   typedef struct packed {
      cmd_type               cmd;
      logic [ADC_BITS-1:0]   sensor_a;
      logic [ADC_BITS-1:0]   sensor_b;
      logic [ADC_BITS-1:0]   sensor_c;
      logic [ADC_BITS-1:0]   sensor_d;
      logic [ADC_BITS-1:0]   sensor_e;
   } req_word_type;

   typedef struct packed {
      logic signed [DRIVE_BITS-1:0] left_drive;
      logic signed [DRIVE_BITS-1:0] right_drive;
      logic                         on_line;
      logic [4:0]                   hold_ms;
      logic                         last;
   } rsp_word_type;

   typedef struct packed {
      logic                 black_line;
      logic [5:0]           line_thickness;
      logic                 brake_enabled;
      logic [7:0]           target_speed;
      logic [15:0]          gain_p;
      logic [15:0]          gain_i;
      logic [15:0]          gain_d;
   } csr_type;

endpackage

>>> rtl/lfpd_stream_if.sv
interface lfpd_stream_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lfpd_front.sv
// Front end: holds calibration, normalizes with a shared restoring divider.
module lfpd_front
   import lfpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   input  logic         q_full,
   output logic         q_push,
   output cmd_type      q_cmd,
   output logic [NORM_BITS-1:0] q_norm [NUM_SENSORS]
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   localparam int NUM_BITS = ADC_BITS + NORM_BITS;
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);
   localparam int SEL_BITS = $clog2(NUM_SENSORS);

   fstate_type state_ff, state_in;
   logic [ADC_BITS-1:0] min_ff [NUM_SENSORS];
   logic [ADC_BITS-1:0] min_in [NUM_SENSORS];
   logic [ADC_BITS-1:0] max_ff [NUM_SENSORS];
   logic [ADC_BITS-1:0] max_in [NUM_SENSORS];
   sample_type raw_ff, raw_in;
   cmd_type cmd_ff, cmd_in;
   logic [SEL_BITS-1:0] sel_ff, sel_in;
   logic [CNT_BITS-1:0] bit_ff, bit_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [ADC_BITS:0]   rem_ff, rem_in;
   logic [NORM_BITS-1:0] norm_ff [NUM_SENSORS];
   logic [NORM_BITS-1:0] norm_in [NUM_SENSORS];
   logic [ADC_BITS-1:0] span, diff;
   logic [NUM_BITS-1:0] dividend;
   logic [CNT_BITS-1:0] bit_pos;
   logic [ADC_BITS:0]   trial;
   logic                below;
   sample_type req_raw;

   assign req_raw[0] = req_word.sensor_a;
   assign req_raw[1] = req_word.sensor_b;
   assign req_raw[2] = req_word.sensor_c;
   assign req_raw[3] = req_word.sensor_d;
   assign req_raw[4] = req_word.sensor_e;

   assign req_ready = (state_ff == F_IDLE);
   assign q_push    = (state_ff == F_PUSH) && !q_full;
   assign q_cmd     = cmd_ff;
   assign q_norm    = norm_ff;

   assign span     = max_ff[sel_ff] - min_ff[sel_ff];
   assign below    = raw_ff[sel_ff] < min_ff[sel_ff];
   assign diff     = raw_ff[sel_ff] - min_ff[sel_ff];
   assign dividend = NUM_BITS'(diff) * NUM_BITS'(NORM_FULL);
   assign bit_pos  = CNT_BITS'(NUM_BITS - 1) - bit_ff;
   assign trial    = {rem_ff[ADC_BITS-1:0], dividend[bit_pos]};

   always_comb begin
      state_in = state_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      raw_in   = raw_ff;
      cmd_in   = cmd_ff;
      sel_in   = sel_ff;
      bit_in   = bit_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      norm_in  = norm_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               cmd_in = req_word.cmd;
               raw_in = req_raw;
               sel_in = '0;
               bit_in = '0;
               quo_in = '0;
               rem_in = '0;
               for (int i = 0; i < NUM_SENSORS; i++) begin
                  if (req_word.cmd == CMD_CAL_START) begin
                     min_in[i] = req_raw[i];
                     max_in[i] = req_raw[i];
                  end else if (req_word.cmd == CMD_CAL_SAMPLE) begin
                     if (req_raw[i] < min_ff[i]) min_in[i] = req_raw[i];
                     if (req_raw[i] > max_ff[i]) max_in[i] = req_raw[i];
                  end
               end
               state_in = (req_word.cmd == CMD_FOLLOW) ? F_DIV : F_PUSH;
            end
         end
         F_DIV: begin
            if (trial >= {1'b0, span}) begin
               rem_in = trial - {1'b0, span};
               quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == CNT_BITS'(NUM_BITS - 1)) begin
               if (span == '0 || below) begin
                  norm_in[sel_ff] = '0;
               end else if (quo_in > NUM_BITS'(NORM_FULL)) begin
                  norm_in[sel_ff] = NORM_FULL;
               end else begin
                  norm_in[sel_ff] = quo_in[NORM_BITS-1:0];
               end
               bit_in = '0;
               quo_in = '0;
               rem_in = '0;
               if (sel_ff == SEL_BITS'(NUM_SENSORS - 1)) begin
                  state_in = F_PUSH;
               end else begin
                  sel_in = sel_ff + 1'b1;
               end
            end
         end
         F_PUSH: begin
            if (!q_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         for (int i = 0; i < NUM_SENSORS; i++) begin
            min_ff[i] <= '0;
            max_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
      raw_ff  <= raw_in;
      cmd_ff  <= cmd_in;
      sel_ff  <= sel_in;
      bit_ff  <= bit_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      norm_ff <= norm_in;
   end

endmodule

>>> rtl/lfpd_queue.sv
module lfpd_queue
   import lfpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic [NORM_BITS-1:0] push_norm [NUM_SENSORS],
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type pop_cmd,
   output logic [NORM_BITS-1:0] pop_norm [NUM_SENSORS]
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   cmd_type cmd_ff [QUEUE_DEPTH];
   logic [NORM_BITS-1:0] norm_ff [QUEUE_DEPTH][NUM_SENSORS];
   logic [PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_BITS:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == (PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_cmd  = cmd_ff[rd_ff];
   assign pop_norm = norm_ff[rd_ff];

   always_comb begin
      wr_in  = (push && !full) ? wr_ff + 1'b1 : wr_ff;
      rd_in  = (pop && !empty) ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PTR_BITS+1)'(push && !full) - (PTR_BITS+1)'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push && !full) begin
         cmd_ff[wr_ff]  <= push_cmd;
         norm_ff[wr_ff] <= push_norm;
      end
   end

endmodule

>>> rtl/lfpd_back.sv
// Back end: detection, ramp, PID with one shared multiplier, result register.
module lfpd_back
   import lfpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    q_empty,
   output logic    q_pop,
   input  cmd_type q_cmd,
   input  logic [NORM_BITS-1:0] q_norm [NUM_SENSORS],
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   typedef enum logic [5:0] {
      B_IDLE  = 6'b000001,
      B_MULP  = 6'b000010,
      B_MULI  = 6'b000100,
      B_MULD  = 6'b001000,
      B_DRIVE = 6'b010000,
      B_EMIT  = 6'b100000
   } bstate_type;

   localparam int PROD_BITS = INT_BITS + 17;
   localparam int ACC_BITS  = PROD_BITS + 2;
   localparam int PID_BITS  = ACC_BITS - GAIN_FRAC_BITS;
   localparam logic signed [INT_BITS-1:0] INT_MAX = {1'b0, {(INT_BITS-1){1'b1}}};
   localparam logic signed [INT_BITS-1:0] INT_MIN = {1'b1, {(INT_BITS-1){1'b0}}};

   bstate_type state_ff, state_in;
   logic [7:0] ramp_ff, ramp_in;
   logic signed [INT_BITS-1:0] isum_ff, isum_in;
   logic signed [ERR_BITS-1:0] prior_ff, prior_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in;
   logic signed [ERR_BITS:0]   derr_ff, derr_in;
   logic recov_ff, recov_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;
   rsp_word_type out_ff, out_in;
   logic valid_ff, valid_in;
   logic brake_ff, brake_in;
   logic signed [DRIVE_BITS-1:0] turn_l_ff, turn_l_in, turn_r_ff, turn_r_in;

   logic seen;
   logic signed [ERR_BITS-1:0] err_raw, err_fix;
   logic signed [INT_BITS:0] isum_wide;
   logic signed [INT_BITS-1:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [PROD_BITS-1:0] prod;
   logic signed [ACC_BITS-1:0] acc_abs, pid_mag_full;
   logic signed [PID_BITS-1:0] pid;
   logic signed [PID_BITS:0] lsum, rsum;

   function automatic logic signed [DRIVE_BITS-1:0] clamp_drive(
      input logic signed [PID_BITS:0] v);
      logic signed [DRIVE_BITS-1:0] r;
      if (v < 0) r = '0;
      else if (v > (PID_BITS+1)'(255)) r = 9'sd255;
      else r = v[DRIVE_BITS-1:0];
      return r;
   endfunction

   assign rsp_valid = valid_ff;
   assign rsp_word  = out_ff;

   always_comb begin
      seen = 1'b0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         if (csr.black_line && q_norm[i] > ON_LEVEL) seen = 1'b1;
         if (!csr.black_line && q_norm[i] < ON_LEVEL) seen = 1'b1;
      end
      err_raw = ERR_BITS'(3) * $signed({3'b0, q_norm[0]}) + $signed({3'b0, q_norm[1]})
              - $signed({3'b0, q_norm[3]}) - ERR_BITS'(3) * $signed({3'b0, q_norm[4]});
      err_fix = err_raw;
      if (csr.line_thickness > THICK_LIMIT) err_fix = -err_fix;
      if (csr.black_line) err_fix = -err_fix;
      isum_wide = (INT_BITS+1)'(isum_ff) + (INT_BITS+1)'(err_fix);
   end

   always_comb begin
      mul_a = INT_BITS'(err_ff);
      mul_b = $signed({1'b0, csr.gain_p});
      case (state_ff)
         B_MULI: begin
            mul_a = isum_ff;
            mul_b = $signed({1'b0, csr.gain_i});
         end
         B_MULD: begin
            mul_a = INT_BITS'(derr_ff);
            mul_b = $signed({1'b0, csr.gain_d});
         end
         default: ;
      endcase
      prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
      acc_abs = acc_ff[ACC_BITS-1] ? -acc_ff : acc_ff;
      pid_mag_full = acc_abs >>> GAIN_FRAC_BITS;
      pid = acc_ff[ACC_BITS-1] ? -pid_mag_full[PID_BITS-1:0] : pid_mag_full[PID_BITS-1:0];
      lsum = (PID_BITS+1)'($signed({1'b0, ramp_ff})) - (PID_BITS+1)'(pid);
      rsum = (PID_BITS+1)'($signed({1'b0, ramp_ff})) + (PID_BITS+1)'(pid);
   end

   always_comb begin
      state_in  = state_ff;
      ramp_in   = ramp_ff;
      isum_in   = isum_ff;
      prior_in  = prior_ff;
      err_in    = err_ff;
      derr_in   = derr_ff;
      recov_in  = recov_ff;
      acc_in    = acc_ff;
      out_in    = out_ff;
      valid_in  = valid_ff;
      brake_in  = brake_ff;
      turn_l_in = turn_l_ff;
      turn_r_in = turn_r_ff;
      q_pop     = 1'b0;
      if (valid_ff && rsp_ready) valid_in = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty && (!valid_ff || rsp_ready)) begin
               q_pop    = 1'b1;
               valid_in = 1'b1;
               out_in   = '0;
               out_in.last = 1'b1;
               case (q_cmd)
                  CMD_CAL_START, CMD_CAL_SAMPLE: begin
                     out_in.left_drive  = SPIN_SPEED;
                     out_in.right_drive = -SPIN_SPEED;
                  end
                  CMD_FOLLOW: begin
                     if (ramp_ff < csr.target_speed) ramp_in = ramp_ff + 1'b1;
                     if (seen) begin
                        valid_in = 1'b0;
                        err_in   = err_fix;
                        derr_in  = (ERR_BITS+1)'(err_fix) - (ERR_BITS+1)'(prior_ff);
                        if (isum_wide > (INT_BITS+1)'(INT_MAX)) isum_in = INT_MAX;
                        else if (isum_wide < (INT_BITS+1)'(INT_MIN)) isum_in = INT_MIN;
                        else isum_in = isum_wide[INT_BITS-1:0];
                        acc_in   = '0;
                        state_in = B_MULP;
                     end else begin
                        turn_l_in = (prior_ff > 0) ? TURN_REV : TURN_FWD;
                        turn_r_in = (prior_ff > 0) ? TURN_FWD : TURN_REV;
                        recov_in  = 1'b1;
                        if (csr.brake_enabled && !recov_ff) begin
                           out_in.hold_ms = BRAKE_MS;
                           out_in.last    = 1'b0;
                           brake_in       = 1'b1;
                           state_in       = B_EMIT;
                        end else begin
                           out_in.left_drive  = turn_l_in;
                           out_in.right_drive = turn_r_in;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         B_MULP: begin
            acc_in   = ACC_BITS'(prod);
            state_in = B_MULI;
         end
         B_MULI: begin
            acc_in   = acc_ff + ACC_BITS'(prod);
            state_in = B_MULD;
         end
         B_MULD: begin
            acc_in   = acc_ff + ACC_BITS'(prod);
            state_in = B_DRIVE;
         end
         B_DRIVE: begin
            if (!valid_ff || rsp_ready) begin
               out_in             = '0;
               out_in.left_drive  = clamp_drive(lsum);
               out_in.right_drive = clamp_drive(rsum);
               out_in.on_line     = 1'b1;
               out_in.last        = 1'b1;
               valid_in           = 1'b1;
               prior_in           = err_ff;
               recov_in           = 1'b0;
               state_in           = B_IDLE;
            end
         end
         B_EMIT: begin
            if (!valid_ff || rsp_ready) begin
               out_in             = '0;
               out_in.left_drive  = turn_l_ff;
               out_in.right_drive = turn_r_ff;
               out_in.last        = 1'b1;
               valid_in           = 1'b1;
               brake_in           = 1'b0;
               state_in           = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         ramp_ff  <= RAMP_RESET;
         isum_ff  <= '0;
         prior_ff <= '0;
         recov_ff <= 1'b0;
         valid_ff <= 1'b0;
         brake_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ramp_ff  <= ramp_in;
         isum_ff  <= isum_in;
         prior_ff <= prior_in;
         recov_ff <= recov_in;
         valid_ff <= valid_in;
         brake_ff <= brake_in;
      end
      err_ff    <= err_in;
      derr_ff   <= derr_in;
      acc_ff    <= acc_in;
      out_ff    <= out_in;
      turn_l_ff <= turn_l_in;
      turn_r_ff <= turn_r_in;
   end

endmodule

>>> rtl/line_follower_pid_drive_core.sv
// Line follower steering core.
// The req channel carries one word per sensor sample: a command and five raw
// readings. The rsp channel returns one or two drive words per request word,
// and the last flag marks the final word of each request.
// A calibration or stop word goes from the front end through the queue to the
// result register, and the next request word is accepted only once the front
// end has handed the previous one to the queue. In a follow step the front end
// uses one shared restoring divider that produces one quotient bit per cycle,
// for each of the five sensors in turn, and then hands the word to the queue.
// The back end then uses one multiplier to form the three PID terms in
// successive cycles before the drive word goes to the result register.
// The user must write registers on the csr port only while the block is idle;
// the block itself does not enforce this. Reset restores register defaults,
// clears calibration and PID state and empties the queue. When the receiver
// stalls, the result register holds its word, the back end waits, and the
// front end keeps working until the queue fills, after which req_ready stays
// low.
module line_follower_pid_drive_core
   import lfpd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   lfpd_stream_if.sink   req,
   lfpd_stream_if.source rsp,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data
);

   csr_type csr_ff, csr_in;
   logic q_full, q_push, q_empty, q_pop;
   cmd_type push_cmd, pop_cmd;
   logic [NORM_BITS-1:0] push_norm [NUM_SENSORS];
   logic [NORM_BITS-1:0] pop_norm [NUM_SENSORS];
   rsp_word_type rsp_word;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BLACK_LINE: csr_in.black_line     = csr_write_data[0];
            CSR_THICKNESS:  csr_in.line_thickness = csr_write_data[5:0];
            CSR_BRAKE:      csr_in.brake_enabled  = csr_write_data[0];
            CSR_TARGET:     csr_in.target_speed   = csr_write_data[7:0];
            CSR_GAIN_P:     csr_in.gain_p         = csr_write_data;
            CSR_GAIN_I:     csr_in.gain_i         = csr_write_data;
            CSR_GAIN_D:     csr_in.gain_d         = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.black_line     <= 1'b1;
         csr_ff.line_thickness <= 6'd25;
         csr_ff.brake_enabled  <= 1'b0;
         csr_ff.target_speed   <= 8'd120;
         csr_ff.gain_p         <= 16'd246;
         csr_ff.gain_i         <= 16'd0;
         csr_ff.gain_d         <= 16'd6144;
      end else begin
         csr_ff <= csr_in;
      end
   end

   lfpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_word  (req_word_type'(req.data)),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd),
      .q_norm    (push_norm)
   );

   lfpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .push_norm (push_norm),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_cmd   (pop_cmd),
      .pop_norm  (pop_norm)
   );

   lfpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_cmd     (pop_cmd),
      .q_norm    (pop_norm),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_word  (rsp_word)
   );

   assign rsp.data = rsp_word;

endmodule

>>> rtl/lfpd_checker.sv
module lfpd_checker
   import lfpd_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   a_req_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while the front end is busy");

   a_brake_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last |-> rsp_word.hold_ms == BRAKE_MS
         && rsp_word.left_drive == '0 && rsp_word.right_drive == '0)
      else $error("non-final word is not a brake pulse");

   a_online_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.on_line |-> !rsp_word.left_drive[DRIVE_BITS-1]
         && !rsp_word.right_drive[DRIVE_BITS-1] && rsp_word.hold_ms == '0)
      else $error("follow drive out of range");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind line_follower_pid_drive_core lfpd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_word  (rsp.data)
);

>>> test/line_follower_pid_drive_core_checker.sv
`timescale 1ns / 1ps

module line_follower_pid_drive_core_checker
   import lfpd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   lfpd_stream_if req,
   lfpd_stream_if rsp,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data,
   output int                       mismatch_count,
   output int                       pending_count,
   output int                       word_count
);

   csr_type regs;
   logic [ADC_BITS-1:0] low_mark [NUM_SENSORS];
   logic [ADC_BITS-1:0] high_mark [NUM_SENSORS];
   logic [7:0] ramp;
   longint integral;
   longint last_error;
   bit recovering;
   rsp_word_type drive_queue [$];

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic rsp_word_type drive_word(longint l, longint r, bit on, logic [4:0] hold,
                                               bit fin);
      rsp_word_type w;
      w.left_drive = l[DRIVE_BITS-1:0];
      w.right_drive = r[DRIVE_BITS-1:0];
      w.on_line = on;
      w.hold_ms = hold;
      w.last = fin;
      return w;
   endfunction

   task automatic steer(req_word_type w);
      logic [ADC_BITS-1:0] raw [NUM_SENSORS];
      longint level [NUM_SENSORS];
      longint span, err, total, pid;
      bit seen;
      raw = '{w.sensor_a, w.sensor_b, w.sensor_c, w.sensor_d, w.sensor_e};
      seen = 0;
      case (w.cmd)
         CMD_CAL_START, CMD_CAL_SAMPLE: begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
               if (w.cmd == CMD_CAL_START) begin
                  low_mark[i] = raw[i];
                  high_mark[i] = raw[i];
               end else begin
                  if (raw[i] < low_mark[i]) low_mark[i] = raw[i];
                  if (raw[i] > high_mark[i]) high_mark[i] = raw[i];
               end
            end
            drive_queue.push_back(drive_word(50, -50, 0, 0, 1));
         end
         CMD_STOP: drive_queue.push_back(drive_word(0, 0, 0, 0, 1));
         default: begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
               span = longint'(high_mark[i]) - longint'(low_mark[i]);
               level[i] = (span == 0) ? 0 :
                  clip(((longint'(raw[i]) - longint'(low_mark[i])) * 1000) / span, 0, 1000);
               if (regs.black_line && level[i] > 700) seen = 1;
               if (!regs.black_line && level[i] < 700) seen = 1;
            end
            if (ramp < regs.target_speed) ramp++;
            if (seen) begin
               err = 3 * level[0] + level[1] - level[3] - 3 * level[4];
               if (regs.line_thickness > 22) err = -err;
               if (regs.black_line) err = -err;
               integral = clip(integral + err, -8388608, 8388607);
               total = longint'(regs.gain_p) * err + longint'(regs.gain_i) * integral
                  + longint'(regs.gain_d) * (err - last_error);
               pid = total / (longint'(1) << GAIN_FRAC_BITS);
               last_error = err;
               recovering = 0;
               drive_queue.push_back(drive_word(clip(ramp - pid, 0, 255),
                                                clip(ramp + pid, 0, 255), 1, 0, 1));
            end else begin
               if (regs.brake_enabled && !recovering)
                  drive_queue.push_back(drive_word(0, 0, 0, BRAKE_MS, 0));
               if (last_error > 0) drive_queue.push_back(drive_word(-100, 150, 0, 0, 1));
               else drive_queue.push_back(drive_word(150, -100, 0, 0, 1));
               recovering = 1;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_word_type got, want;
      if (reset) begin
         regs <= '{1'b1, 6'd25, 1'b0, 8'd120, 16'd246, 16'd0, 16'd6144};
         for (int i = 0; i < NUM_SENSORS; i++) begin
            low_mark[i] = '0;
            high_mark[i] = '0;
         end
         ramp = RAMP_RESET;
         integral = 0;
         last_error = 0;
         recovering = 0;
         drive_queue.delete();
         mismatch_count <= 0;
         word_count <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_BLACK_LINE: regs.black_line <= csr_write_data[0];
               CSR_THICKNESS:  regs.line_thickness <= csr_write_data[5:0];
               CSR_BRAKE:      regs.brake_enabled <= csr_write_data[0];
               CSR_TARGET:     regs.target_speed <= csr_write_data[7:0];
               CSR_GAIN_P:     regs.gain_p <= csr_write_data;
               CSR_GAIN_I:     regs.gain_i <= csr_write_data;
               CSR_GAIN_D:     regs.gain_d <= csr_write_data;
               default: ;
            endcase
         end
         if (req.valid && req.ready) steer(req_word_type'(req.data));
         if (rsp.valid && rsp.ready) begin
            got = rsp_word_type'(rsp.data);
            word_count <= word_count + 1;
            if (drive_queue.size() == 0) begin
               if (mismatch_count < 10)
                  $display("Unexpected result word %p", got);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = drive_queue.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display("Mismatch: expected %p, got %p", want, got);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
      pending_count = drive_queue.size();
   end

endmodule

>>> test/line_follower_pid_drive_core_test.sv
`timescale 1ns / 1ps

module line_follower_pid_drive_core_test;
   import lfpd_pkg::*;

   localparam int REQ_WIDTH = $bits(req_word_type);
   localparam int RSP_WIDTH = $bits(rsp_word_type);

   logic clock = 0;
   logic reset = 1;
   logic                     csr_write_enable = 0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;
   int mismatch_count, pending_count, word_count;
   int stall_hold = 0;
   bit hold_request = 0;
   bit hold_seen = 0;
   bit calm = 0;
   int follow_words = 0;

   lfpd_stream_if #(.WIDTH(REQ_WIDTH)) req ();
   lfpd_stream_if #(.WIDTH(RSP_WIDTH)) rsp ();

   line_follower_pid_drive_core DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   line_follower_pid_drive_core_checker checker_unit (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .mismatch_count(mismatch_count),
      .pending_count(pending_count), .word_count(word_count)
   );

   always #10 clock = ~clock;

   initial begin
      req.valid = 0;
      req.data = '0;
   end

   initial begin
      #20ms;
      $display("line_follower_pid_drive_core test failed");
      $finish;
   end

   // The receiver stalls in random bursts, or for a long hold when asked.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else if (hold_request != hold_seen) begin
         rsp.ready <= 0;
         stall_hold <= 400;
         hold_seen <= hold_request;
      end else if (stall_hold > 0) begin
         rsp.ready <= 0;
         stall_hold <= stall_hold - 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp.ready <= 0;
         stall_hold <= $urandom_range(0, 10);
      end else begin
         rsp.ready <= 1;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic send(cmd_type cmd, logic [ADC_BITS-1:0] s [NUM_SENSORS]);
      req_word_type w;
      if (!calm && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 11)) @(negedge clock);
      w = '{cmd, s[0], s[1], s[2], s[3], s[4]};
      req.valid = 1;
      req.data = w;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
      req.valid = 0;
      if (cmd == CMD_FOLLOW) follow_words++;
   endtask

   function automatic logic [ADC_BITS-1:0] reading(int lo, int hi);
      return ADC_BITS'($urandom_range(lo, hi));
   endfunction

   // Calibrates on a dark and a light sample, then follows random readings, with random commands mixed in.
   task automatic lap(int count);
      logic [ADC_BITS-1:0] s [NUM_SENSORS];
      int base, band;
      base = $urandom_range(0, 1500);
      band = $urandom_range(1, 2595);
      foreach (s[i]) s[i] = reading(base, base + 30);
      send(CMD_CAL_START, s);
      foreach (s[i]) s[i] = reading(base + band - 30 > base ? base + band - 30 : base,
                                    base + band);
      send(CMD_CAL_SAMPLE, s);
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0: foreach (s[i]) s[i] = reading(0, 4095);
            1: send(cmd_type'($urandom_range(0, 3)), s);
            2: foreach (s[i]) s[i] = reading(base, base + band / 2);
            default: foreach (s[i]) s[i] = reading(base, base + band);
         endcase
         send(CMD_FOLLOW, s);
      end
   endtask

   initial begin
      logic [ADC_BITS-1:0] s [NUM_SENSORS];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (s[i]) s[i] = '1;
      send(CMD_FOLLOW, s);
      send(CMD_STOP, s);
      s = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
      send(CMD_CAL_START, s);
      s = '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095};
      send(CMD_CAL_SAMPLE, s);
      s = '{12'd4095, 12'd0, 12'd0, 12'd0, 12'd0};
      send(CMD_FOLLOW, s);
      s = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd4095};
      send(CMD_FOLLOW, s);
      s = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
      send(CMD_FOLLOW, s);
      send(CMD_FOLLOW, s);
      s = '{12'd2867, 12'd2868, 12'd2866, 12'd4095, 12'd1000};
      send(CMD_FOLLOW, s);
      drain();

      write_reg(CSR_BRAKE, 1);
      write_reg(CSR_BLACK_LINE, 0);
      write_reg(CSR_THICKNESS, 10);
      s = '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095};
      send(CMD_FOLLOW, s);
      send(CMD_FOLLOW, s);
      s = '{12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095};
      send(CMD_FOLLOW, s);
      send(CMD_STOP, s);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         write_reg(CSR_BLACK_LINE, $urandom_range(0, 1));
         write_reg(CSR_THICKNESS, phase == 1 ? 6'd63 : (phase == 2 ? 6'd0 : $urandom_range(10, 35)));
         write_reg(CSR_BRAKE, $urandom_range(0, 1));
         write_reg(CSR_TARGET, phase == 0 ? 8'd255 : (phase == 1 ? 8'd0 : $urandom_range(0, 255)));
         write_reg(CSR_GAIN_P, phase == 0 ? 16'hFFFF : (phase == 1 ? 16'd0 : $urandom_range(0, 4000)));
         write_reg(CSR_GAIN_I, phase == 0 ? 16'hFFFF : (phase == 1 ? 16'd0 : $urandom_range(0, 64)));
         write_reg(CSR_GAIN_D, phase == 0 ? 16'hFFFF : (phase == 1 ? 16'd0 : $urandom_range(0, 9000)));
         if (phase == 3) begin
            fork
               begin
                  @(posedge clock);
                  hold_request = ~hold_request;
               end
               lap(20);
            join
         end else begin
            calm = phase == 7;
            lap(160);
         end
         drain();
      end

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Sent %0d follow words over eight register settings; %0d drive words checked.",
                  follow_words, word_count);
         $display("line_follower_pid_drive_core test passed");
      end else begin
         $display("line_follower_pid_drive_core test failed");
      end
      $finish;
   end

endmodule
